// ----- hdl/rns_pkg.sv -----
// shared types and constants of the residue number system arithmetic unit
package rns_pkg;

	typedef enum logic [2:0] {
		FN_ADD      = 3'd0,
		FN_SUB      = 3'd1,
		FN_MUL      = 3'd2,
		FN_FROM_INT = 3'd3,
		FN_TO_INT   = 3'd4,
		FN_CMP      = 3'd5
	} func_t;

	localparam logic signed [1:0] ORD_LT = -2'sd1;
	localparam logic signed [1:0] ORD_EQ = 2'sd0;
	localparam logic signed [1:0] ORD_GT = 2'sd1;

	localparam int unsigned NUM_LANES   = 4;
	localparam int unsigned RES_W       = 8;
	localparam int unsigned PRE_W       = 18;
	localparam int unsigned RECIP_W     = 19;
	localparam int unsigned RECIP_SHIFT = 26;
	localparam int unsigned QUO_W       = PRE_W + RECIP_W - RECIP_SHIFT;

	typedef logic [RES_W-1:0]           res_t;
	typedef logic [PRE_W-1:0]           pre_t;
	typedef logic [RECIP_W-1:0]         recip_t;
	typedef logic [QUO_W-1:0]           quo_t;
	typedef logic [PRE_W+RECIP_W-1:0]   prod_t;
	typedef logic [23:0]                crt_m_t;

	// per stage advance strobes of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} pipe_en_t;

	localparam res_t MODULI [NUM_LANES] = '{8'd233, 8'd239, 8'd241, 8'd251};

	localparam logic [31:0] MOD_PRODUCT = 32'd3368562317;
	localparam logic [31:0] INT_DELTA   = 32'd926404979;
	localparam logic [31:0] MID_POINT   = 32'd1684281159;

	localparam logic [31:0] CRT_W [NUM_LANES] = '{
		32'd3021585941, 32'd1099363434, 32'd1663315003, 32'd952860257
	};

	// M / m_i
	localparam crt_m_t CRT_M [NUM_LANES] = '{
		crt_m_t'(MOD_PRODUCT / 32'(MODULI[0])),
		crt_m_t'(MOD_PRODUCT / 32'(MODULI[1])),
		crt_m_t'(MOD_PRODUCT / 32'(MODULI[2])),
		crt_m_t'(MOD_PRODUCT / 32'(MODULI[3]))
	};

	// crt weight = (M / m_i) * k_i with k_i below m_i
	localparam res_t CRT_K [NUM_LANES] = '{
		res_t'(CRT_W[0] / 32'(CRT_M[0])),
		res_t'(CRT_W[1] / 32'(CRT_M[1])),
		res_t'(CRT_W[2] / 32'(CRT_M[2])),
		res_t'(CRT_W[3] / 32'(CRT_M[3]))
	};

	// floor(2^shift / m_i), quotient estimate is exact or one low
	localparam recip_t RECIP [NUM_LANES] = '{
		recip_t'((64'd1 << RECIP_SHIFT) / 64'(MODULI[0])),
		recip_t'((64'd1 << RECIP_SHIFT) / 64'(MODULI[1])),
		recip_t'((64'd1 << RECIP_SHIFT) / 64'(MODULI[2])),
		recip_t'((64'd1 << RECIP_SHIFT) / 64'(MODULI[3]))
	};

	// 256^j mod m_i for the byte weights of an integer
	localparam res_t POW1 [NUM_LANES] = '{
		res_t'(32'd256 % 32'(MODULI[0])), res_t'(32'd256 % 32'(MODULI[1])),
		res_t'(32'd256 % 32'(MODULI[2])), res_t'(32'd256 % 32'(MODULI[3]))
	};
	localparam res_t POW2 [NUM_LANES] = '{
		res_t'(32'd65536 % 32'(MODULI[0])), res_t'(32'd65536 % 32'(MODULI[1])),
		res_t'(32'd65536 % 32'(MODULI[2])), res_t'(32'd65536 % 32'(MODULI[3]))
	};
	localparam res_t POW3 [NUM_LANES] = '{
		res_t'(32'd16777216 % 32'(MODULI[0])), res_t'(32'd16777216 % 32'(MODULI[1])),
		res_t'(32'd16777216 % 32'(MODULI[2])), res_t'(32'd16777216 % 32'(MODULI[3]))
	};

endpackage

// ----- hdl/rns_lane.sv -----
// one residue lane: operand select and reciprocal based reduction modulo its modulus
module rns_lane #(
	parameter int unsigned LANE = 0
) (
	input  logic               clk,
	input  rns_pkg::pipe_en_t  en,
	input  rns_pkg::func_t     func_s1,
	input  logic [31:0]        a_s1,
	input  logic [31:0]        b_s1,
	output rns_pkg::res_t      res_a_s4,
	output rns_pkg::res_t      res_b_s4
);

	localparam rns_pkg::res_t   M     = rns_pkg::MODULI[LANE];
	localparam rns_pkg::res_t   K     = rns_pkg::CRT_K[LANE];
	localparam rns_pkg::recip_t R     = rns_pkg::RECIP[LANE];
	localparam rns_pkg::res_t   P1    = rns_pkg::POW1[LANE];
	localparam rns_pkg::res_t   P2    = rns_pkg::POW2[LANE];
	localparam rns_pkg::res_t   P3    = rns_pkg::POW3[LANE];
	localparam int unsigned     RW    = rns_pkg::RES_W;

	rns_pkg::res_t  x, y, xr, yr;
	rns_pkg::pre_t  pre  [2];
	rns_pkg::pre_t  p_s2 [2];
	rns_pkg::prod_t prod [2];
	rns_pkg::quo_t  q_s3 [2];
	rns_pkg::pre_t  p_s3 [2];
	rns_pkg::pre_t  diff [2];
	logic [RW:0]    r9   [2];
	rns_pkg::res_t  red  [2];

	// channel 0 carries the op, channel 1 the second compare operand
	always_comb begin
		x  = a_s1[RW*LANE +: RW];
		y  = b_s1[RW*LANE +: RW];
		xr = (x >= M) ? x - M : x;
		yr = (y >= M) ? y - M : y;
		case (func_s1)
			rns_pkg::FN_ADD:      pre[0] = rns_pkg::pre_t'(x) + rns_pkg::pre_t'(y);
			rns_pkg::FN_SUB:      pre[0] = rns_pkg::pre_t'(x) + rns_pkg::pre_t'(M - yr);
			rns_pkg::FN_MUL:      pre[0] = rns_pkg::pre_t'(xr) * rns_pkg::pre_t'(yr);
			rns_pkg::FN_FROM_INT: begin
				pre[0] = rns_pkg::pre_t'(a_s1[7:0])
					+ rns_pkg::pre_t'(a_s1[15:8]) * rns_pkg::pre_t'(P1)
					+ rns_pkg::pre_t'(a_s1[23:16]) * rns_pkg::pre_t'(P2)
					+ rns_pkg::pre_t'(a_s1[31:24]) * rns_pkg::pre_t'(P3);
			end
			rns_pkg::FN_TO_INT,
			rns_pkg::FN_CMP:      pre[0] = rns_pkg::pre_t'(x) * rns_pkg::pre_t'(K);
			default:              pre[0] = '0;
		endcase
		pre[1] = rns_pkg::pre_t'(y) * rns_pkg::pre_t'(K);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_s2 <= pre;
		end
	end

	// quotient estimate
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			prod[i] = rns_pkg::prod_t'(p_s2[i]) * rns_pkg::prod_t'(R);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < 2; i++) begin
				q_s3[i] <= prod[i][rns_pkg::RECIP_SHIFT +: rns_pkg::QUO_W];
				p_s3[i] <= p_s2[i];
			end
		end
	end

	// remainder below twice the modulus, one correction step
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			diff[i] = p_s3[i] - rns_pkg::pre_t'(q_s3[i]) * rns_pkg::pre_t'(M);
			r9[i]   = diff[i][RW:0];
			red[i]  = (r9[i] >= (RW+1)'(M)) ? RW'(r9[i] - (RW+1)'(M)) : RW'(r9[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_a_s4 <= red[0];
			res_b_s4 <= red[1];
		end
	end

endmodule

// ----- hdl/rns_crt.sv -----
// crt merge of the four lane residues into a value modulo the product of the moduli
module rns_crt (
	input  logic                                        clk,
	input  rns_pkg::pipe_en_t                           en,
	input  logic [rns_pkg::NUM_LANES-1:0][rns_pkg::RES_W-1:0] res_s4,
	output logic [31:0]                                 value_s7
);

	localparam logic [33:0] M1 = 34'(rns_pkg::MOD_PRODUCT);
	localparam logic [33:0] M2 = M1 * 34'd2;
	localparam logic [33:0] M3 = M1 * 34'd3;

	logic [31:0] w_s5 [rns_pkg::NUM_LANES];
	logic [33:0] sum_s6;
	logic [33:0] folded;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int i = 0; i < rns_pkg::NUM_LANES; i++) begin
				w_s5[i] <= 32'(rns_pkg::CRT_M[i]) * 32'(res_s4[i]);
			end
		end
		if (en.s6) begin
			sum_s6 <= 34'(w_s5[0]) + 34'(w_s5[1]) + 34'(w_s5[2]) + 34'(w_s5[3]);
		end
		if (en.s7) begin
			value_s7 <= folded[31:0];
		end
	end

	// each weighted term is below M, so the sum is below 4M
	always_comb begin
		if (sum_s6 >= M3) begin
			folded = sum_s6 - M3;
		end else if (sum_s6 >= M2) begin
			folded = sum_s6 - M2;
		end else if (sum_s6 >= M1) begin
			folded = sum_s6 - M1;
		end else begin
			folded = sum_s6;
		end
	end

endmodule

// ----- hdl/rns_arithmetic_unit.sv -----
// top level of the residue number system arithmetic unit
//
// rns arithmetic unit over the moduli 233, 239, 241 and 251; a number is four
// 8-bit residues packed into 32 bits, byte i for modulus i. every accepted
// transfer yields exactly one result transfer, in order. the unit takes one
// item per cycle while the result side does not stall; an item passes one
// input stage, three stages per residue lane (operand select,
// reciprocal multiply, remainder correction), three crt merge stages
// (weighted products, sum, fold modulo M) and the output register. the depth
// is set by the reciprocal reduction in the lanes and the crt sum. when the
// result side stalls, stages fill up behind the output register and in_stall
// rises only once every stage holds an item, so up to 8 items are in flight.
// compare works on the crt values of both operands, which orders the numbers
// exactly as their mixed radix digits do
module rns_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic [31:0]        operand_a,
	input  logic [31:0]        operand_b,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        result_value,
	output logic signed [1:0]  order
);

	rns_pkg::pipe_en_t en;
	logic              en_out;

	// stage occupancy
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic out_valid_q;

	rns_pkg::func_t func_in;
	rns_pkg::func_t func_s1, func_s2, func_s3, func_s4, func_s5, func_s6, func_s7;
	logic [31:0]    a_in;
	logic [31:0]    a_s1, b_s1;

	logic [rns_pkg::NUM_LANES-1:0][rns_pkg::RES_W-1:0] res_a_s4, res_b_s4;
	logic [31:0] packed_s5, packed_s6, packed_s7;
	logic [31:0] xa_s7, xb_s7;

	logic [31:0]        res_nx;
	logic signed [1:0]  ord_nx;
	logic [31:0]        result_value_q;
	logic signed [1:0]  order_q;

	// a stage advances when it is empty or the stage after it advances
	assign en_out = !out_valid_q || !out_stall;
	assign en.s7  = !v_s7 || en_out;
	assign en.s6  = !v_s6 || en.s7;
	assign en.s5  = !v_s5 || en.s6;
	assign en.s4  = !v_s4 || en.s5;
	assign en.s3  = !v_s3 || en.s4;
	assign en.s2  = !v_s2 || en.s3;
	assign en.s1  = !v_s1 || en.s2;

	assign in_stall = !en.s1;

	assign func_in = rns_pkg::func_t'(func);

	// negative integers are shifted by the delta before conversion
	assign a_in = (func_in == rns_pkg::FN_FROM_INT && operand_a[31])
		? operand_a - rns_pkg::INT_DELTA : operand_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
			if (en.s7) v_s7 <= v_s6;
			if (en_out) out_valid_q <= v_s7;
		end
	end

	// payload follows its stage, no reset needed
	always_ff @(posedge clk) begin
		if (en.s1) begin
			func_s1 <= func_in;
			a_s1    <= a_in;
			b_s1    <= operand_b;
		end
		if (en.s2) func_s2 <= func_s1;
		if (en.s3) func_s3 <= func_s2;
		if (en.s4) func_s4 <= func_s3;
		if (en.s5) begin
			func_s5   <= func_s4;
			packed_s5 <= res_a_s4;
		end
		if (en.s6) begin
			func_s6   <= func_s5;
			packed_s6 <= packed_s5;
		end
		if (en.s7) begin
			func_s7   <= func_s6;
			packed_s7 <= packed_s6;
		end
	end

	// one lane per modulus
	for (genvar g = 0; g < rns_pkg::NUM_LANES; g++) begin : g_lane
		rns_lane #(
			.LANE (g)
		) u_lane (
			.clk      (clk),
			.en       (en),
			.func_s1  (func_s1),
			.a_s1     (a_s1),
			.b_s1     (b_s1),
			.res_a_s4 (res_a_s4[g]),
			.res_b_s4 (res_b_s4[g])
		);
	end

	// crt merge of the first and second operand
	rns_crt u_crt_a (
		.clk      (clk),
		.en       (en),
		.res_s4   (res_a_s4),
		.value_s7 (xa_s7)
	);

	rns_crt u_crt_b (
		.clk      (clk),
		.en       (en),
		.res_s4   (res_b_s4),
		.value_s7 (xb_s7)
	);

	// final selection per operation
	always_comb begin
		res_nx = '0;
		ord_nx = rns_pkg::ORD_EQ;
		case (func_s7)
			rns_pkg::FN_ADD,
			rns_pkg::FN_SUB,
			rns_pkg::FN_MUL,
			rns_pkg::FN_FROM_INT: res_nx = packed_s7;
			rns_pkg::FN_TO_INT: begin
				// upper half of the range maps back to negative integers
				res_nx = (xa_s7 >= rns_pkg::MID_POINT) ? xa_s7 + rns_pkg::INT_DELTA : xa_s7;
			end
			rns_pkg::FN_CMP: begin
				if (xa_s7 > xb_s7) begin
					ord_nx = rns_pkg::ORD_GT;
				end else if (xa_s7 < xb_s7) begin
					ord_nx = rns_pkg::ORD_LT;
				end else begin
					ord_nx = rns_pkg::ORD_EQ;
				end
			end
			default: begin
				res_nx = '0;
				ord_nx = rns_pkg::ORD_EQ;
			end
		endcase
	end

	// output register holds while the result side stalls
	always_ff @(posedge clk) begin
		if (en_out) begin
			result_value_q <= res_nx;
			order_q        <= ord_nx;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign order        = order_q;

endmodule

// ----- hdl/rns_checker.sv -----
// port level checks of the rns arithmetic unit and their binding
module rns_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [31:0]        result_value,
	input logic signed [1:0]  order
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transfer dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_value) && $stable(order))
		else $error("result payload changed while stalled");

	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (order == rns_pkg::ORD_LT || order == rns_pkg::ORD_EQ
			|| order == rns_pkg::ORD_GT))
		else $error("illegal compare outcome");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && order != rns_pkg::ORD_EQ |-> result_value == 32'd0)
		else $error("compare result carries a nonzero value");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output register");

endmodule

bind rns_arithmetic_unit rns_checker u_rns_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value),
	.order        (order)
);
